[rtl/agkf_pkg.sv]
`timescale 1ns / 1ps

package agkf_pkg;

   // register indexes on the csr port
   localparam int CSR_ADDR_W = 2;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NOISE_ANGLE = 2'd0,
      CSR_NOISE_BIAS  = 2'd1,
      CSR_NOISE_MEAS  = 2'd2
   } agkf_csr_type;

   // register reset values (Q0.32)
   localparam logic [31:0] NOISE_ANGLE_RESET = 32'd4294967;
   localparam logic [31:0] NOISE_BIAS_RESET  = 32'd12884902;
   localparam logic [31:0] NOISE_MEAS_RESET  = 32'd128849019;

   // wide working width used before saturation
   localparam int SAT_W = 68;

   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
      logic [15:0]        time_step;
   } agkf_req_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] estimated_bias;
   } agkf_rsp_type;

   // clamp a wide signed value to 32-bit signed
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/angle_gyro_kalman_filter_core.sv]
`timescale 1ns / 1ps

// Two-state angle / gyro-bias Kalman filter, fixed point.
// Input channel req_*: one word carries measured angle and gyro rate (Q16.16)
// and the time step (Q0.16). Result channel rsp_*: one word per input with the
// filtered angle and the bias estimate (Q16.16, saturated).
// Noise registers are to be written through csr_we / csr_addr / csr_wdata
// only while idle; the block itself does not enforce this.
// A single shared 34x33 multiplier is used ten times, each use with a
// multiply state and a round-and-store state; state ST_PX forms the
// off-diagonal prediction; a radix-2 restoring divider yields the two
// gains at one quotient bit per cycle, with a setup and a finish state
// per gain. req_ready is high only while the sequencer is idle, so a new
// word is not accepted until the sequencer has finished the last one.
// The result sits in an output register; a new word is accepted while it
// waits. If the next result is done while the receiver still stalls, the
// sequencer holds in its last step until the output register frees up.
// Synchronous reset clears the estimates and covariance to zero and loads
// the default noise values.
module angle_gyro_kalman_filter_core
   import agkf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  agkf_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output agkf_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]           csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_PA_W, ST_PA, ST_PT_W, ST_PT, ST_PX, ST_P00_W, ST_P00,
      ST_P11_W, ST_P11, ST_DINIT, ST_DRUN, ST_DFIN, ST_CA_W, ST_CA, ST_CB_W,
      ST_CB, ST_C00_W, ST_C00, ST_C01_W, ST_C01, ST_C10_W, ST_C10, ST_C11_W,
      ST_C11
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] noise_a_ff, noise_a_in, noise_b_ff, noise_b_in, noise_m_ff, noise_m_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] meas_ff, meas_in, ang_ff, ang_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [33:0] t_ff, t_in, s_ff, s_in;
   logic signed [31:0] np00_ff, np00_in, np01_ff, np01_in;
   logic signed [31:0] np10_ff, np10_in, np11_ff, np11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [33:0] op_a_ff, op_a_in;
   logic signed [32:0] op_b_ff, op_b_in;
   logic signed [66:0] prod_ff, prod_in;
   logic               gsel_ff, gsel_in, dneg_ff, dneg_in, dov_ff, dov_in;
   logic               dzero_ff, dzero_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        dlow_ff, dlow_in, quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   agkf_rsp_type       rsp_data_ff, rsp_data_in;

   // rounded products (round half up, floor shift)
   logic signed [66:0] rnd16, rnd18, rnd30;
   assign rnd16 = (prod_ff + 67'sd32768) >>> 16;
   assign rnd18 = (prod_ff + 67'sd131072) >>> 18;
   assign rnd30 = (prod_ff + 67'sd536870912) >>> 30;

   // angle and measurement noise registers converted to Q2.30
   logic [30:0] qa, rn;
   logic [32:0] qa_sum, rn_sum;
   assign qa_sum = {1'b0, noise_a_ff} + 33'd2;
   assign rn_sum = {1'b0, noise_m_ff} + 33'd2;
   assign qa     = qa_sum[32:2];
   assign rn     = rn_sum[32:2];

   // shared operand terms
   logic signed [32:0] dt_op, y_op;
   logic signed [33:0] inner;
   assign dt_op = $signed({17'b0, dt_ff});
   assign y_op  = 33'(meas_ff) - 33'(ang_ff);
   assign inner = t_ff - 34'(p01_ff) - 34'(p10_ff) + $signed({3'b0, qa});

   // divider setup and step
   logic signed [31:0] dnum;
   logic [32:0]        dabs;
   logic [34:0]        rem2;
   logic [35:0]        diff;
   logic signed [31:0] gain_val;
   assign dnum = gsel_ff ? np10_ff : np00_ff;
   assign dabs = dnum[31] ? (33'd0 - 33'(dnum)) : 33'(dnum);
   assign rem2 = {rem_ff, dlow_ff[31]};
   assign diff = {1'b0, rem2} - {2'b0, s_ff[33:0]};

   always_comb begin
      if (dzero_ff) begin
         gain_val = '0;
      end else if (dov_ff || quo_ff[31]) begin
         gain_val = dneg_ff ? 32'sh80000000 : 32'sh7fffffff;
      end else if (dneg_ff) begin
         gain_val = 32'sd0 - $signed({1'b0, quo_ff[30:0]});
      end else begin
         gain_val = $signed({1'b0, quo_ff[30:0]});
      end
   end

   // next-state and datapath
   always_comb begin
      state_in     = state_ff;
      noise_a_in   = noise_a_ff;
      noise_b_in   = noise_b_ff;
      noise_m_in   = noise_m_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      ang_in       = ang_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      np00_in      = np00_ff;
      np01_in      = np01_ff;
      np10_in      = np10_ff;
      np11_in      = np11_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      prod_in      = op_a_ff * op_b_ff;
      gsel_in      = gsel_ff;
      dneg_in      = dneg_ff;
      dov_in       = dov_ff;
      dzero_in     = dzero_ff;
      rem_in       = rem_ff;
      dlow_in      = dlow_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NOISE_ANGLE: noise_a_in = csr_wdata;
            CSR_NOISE_BIAS:  noise_b_in = csr_wdata;
            CSR_NOISE_MEAS:  noise_m_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = req_data.measured_angle;
               dt_in    = req_data.time_step;
               op_a_in  = 34'(req_data.gyro_rate) - 34'(bias_ff);
               op_b_in  = $signed({17'b0, req_data.time_step});
               state_in = ST_PA_W;
            end
         end
         ST_PA_W: state_in = ST_PA;
         ST_PA: begin
            // predicted angle
            ang_in   = sat32(SAT_W'(angle_ff) + SAT_W'(rnd16));
            op_a_in  = 34'(p11_ff);
            op_b_in  = dt_op;
            state_in = ST_PT_W;
         end
         ST_PT_W: state_in = ST_PT;
         ST_PT: begin
            t_in     = 34'(rnd16);
            state_in = ST_PX;
         end
         ST_PX: begin
            np01_in  = sat32(SAT_W'(p01_ff) - SAT_W'(t_ff));
            np10_in  = sat32(SAT_W'(p10_ff) - SAT_W'(t_ff));
            op_a_in  = inner;
            op_b_in  = dt_op;
            state_in = ST_P00_W;
         end
         ST_P00_W: state_in = ST_P00;
         ST_P00: begin
            np00_in  = sat32(SAT_W'(p00_ff) + SAT_W'(rnd16));
            op_a_in  = $signed({2'b0, noise_b_ff});
            op_b_in  = dt_op;
            state_in = ST_P11_W;
         end
         ST_P11_W: state_in = ST_P11;
         ST_P11: begin
            np11_in  = sat32(SAT_W'(p11_ff) + SAT_W'(rnd18));
            s_in     = 34'(np00_ff) + $signed({3'b0, rn});
            gsel_in  = 1'b0;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            // set up |num| * 2^30 / s
            dzero_in = s_ff[33] || (s_ff == 34'sd0);
            dneg_in  = dnum[31];
            dov_in   = {4'b0, dabs[31:2]} >= s_ff[33:0];
            rem_in   = {4'b0, dabs[31:2]};
            dlow_in  = {dabs[1:0], 30'b0};
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DRUN;
         end
         ST_DRUN: begin
            // one quotient bit per cycle
            if (!diff[35]) begin
               rem_in = diff[33:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem2[33:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dlow_in = {dlow_ff[30:0], 1'b0};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            if (!gsel_ff) begin
               k0_in    = gain_val;
               gsel_in  = 1'b1;
               state_in = ST_DINIT;
            end else begin
               k1_in    = gain_val;
               op_a_in  = 34'(k0_ff);
               op_b_in  = y_op;
               state_in = ST_CA_W;
            end
         end
         ST_CA_W: state_in = ST_CA;
         ST_CA: begin
            angle_in = sat32(SAT_W'(ang_ff) + SAT_W'(rnd30));
            op_a_in  = 34'(k1_ff);
            op_b_in  = y_op;
            state_in = ST_CB_W;
         end
         ST_CB_W: state_in = ST_CB;
         ST_CB: begin
            bias_in  = sat32(SAT_W'(bias_ff) + SAT_W'(rnd30));
            op_a_in  = 34'(k0_ff);
            op_b_in  = 33'(np00_ff);
            state_in = ST_C00_W;
         end
         ST_C00_W: state_in = ST_C00;
         ST_C00: begin
            p00_in   = sat32(SAT_W'(np00_ff) - SAT_W'(rnd30));
            op_a_in  = 34'(k0_ff);
            op_b_in  = 33'(np01_ff);
            state_in = ST_C01_W;
         end
         ST_C01_W: state_in = ST_C01;
         ST_C01: begin
            p01_in   = sat32(SAT_W'(np01_ff) - SAT_W'(rnd30));
            op_a_in  = 34'(k1_ff);
            op_b_in  = 33'(np00_ff);
            state_in = ST_C10_W;
         end
         ST_C10_W: state_in = ST_C10;
         ST_C10: begin
            p10_in   = sat32(SAT_W'(np10_ff) - SAT_W'(rnd30));
            op_a_in  = 34'(k1_ff);
            op_b_in  = 33'(np01_ff);
            state_in = ST_C11_W;
         end
         ST_C11_W: state_in = ST_C11;
         ST_C11: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               p11_in       = sat32(SAT_W'(np11_ff) - SAT_W'(rnd30));
               rsp_valid_in = 1'b1;
               rsp_data_in.filtered_angle = angle_ff;
               rsp_data_in.estimated_bias = bias_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         noise_a_ff   <= NOISE_ANGLE_RESET;
         noise_b_ff   <= NOISE_BIAS_RESET;
         noise_m_ff   <= NOISE_MEAS_RESET;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p00_ff       <= '0;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         gsel_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         noise_a_ff   <= noise_a_in;
         noise_b_ff   <= noise_b_in;
         noise_m_ff   <= noise_m_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         rsp_valid_ff <= rsp_valid_in;
         gsel_ff      <= gsel_in;
         cnt_ff       <= cnt_in;
      end
      meas_ff     <= meas_in;
      dt_ff       <= dt_in;
      ang_ff      <= ang_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      np00_ff     <= np00_in;
      np01_ff     <= np01_in;
      np10_ff     <= np10_in;
      np11_ff     <= np11_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      prod_ff     <= prod_in;
      dneg_ff     <= dneg_in;
      dov_ff      <= dov_in;
      dzero_ff    <= dzero_in;
      rem_ff      <= rem_in;
      dlow_ff     <= dlow_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[test/angle_gyro_kalman_filter_core_test.sv]
`timescale 1ns / 1ps

module angle_gyro_kalman_filter_core_test
   import agkf_pkg::*;
();

   // index past the last register, ignored by the block
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_WORDS = 1450;
   localparam int SETTLE_CYCLES = 150;

   // predicts filter outputs and holds the outstanding estimates
   class kalman_scoreboard;
      logic [31:0] noise_angle, noise_bias, noise_meas;
      longint angle_est, bias_est;
      longint cov[4];
      agkf_rsp_type estimate_q[$];
      int mismatches;

      function new();
         noise_angle = NOISE_ANGLE_RESET;
         noise_bias = NOISE_BIAS_RESET;
         noise_meas = NOISE_MEAS_RESET;
         angle_est = 0;
         bias_est = 0;
         foreach (cov[i]) cov[i] = 0;
         mismatches = 0;
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // round half up, floor shift
      static function longint round_shift(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      static function longint gain(longint num, longint den);
         if (den <= 0) return 0;
         return clamp32((num * (64'sd1 <<< 30)) / den);
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_NOISE_ANGLE: noise_angle = v;
            CSR_NOISE_BIAS:  noise_bias = v;
            CSR_NOISE_MEAS:  noise_meas = v;
            default: ;
         endcase
      endfunction

      // run one filter step and queue the expected word
      function void note_input(agkf_req_type w);
         longint meas, rate, dt, qa, qb, r, t, inner, y, s;
         longint np00, np01, np10, np11, k0, k1, ang;
         agkf_rsp_type e;
         meas = longint'(w.measured_angle);
         rate = longint'(w.gyro_rate);
         dt = longint'({48'd0, w.time_step});
         qa = (longint'({32'd0, noise_angle}) + 2) >>> 2;
         qb = longint'({32'd0, noise_bias});
         r = (longint'({32'd0, noise_meas}) + 2) >>> 2;

         // predict
         ang = clamp32(angle_est + round_shift((rate - bias_est) * dt, 16));
         t = round_shift(dt * cov[3], 16);
         inner = t - cov[1] - cov[2] + qa;
         np00 = clamp32(cov[0] + round_shift(dt * inner, 16));
         np01 = clamp32(cov[1] - t);
         np10 = clamp32(cov[2] - t);
         np11 = clamp32(cov[3] + round_shift(qb * dt, 18));

         // gains, zero when the innovation variance is not positive
         s = np00 + r;
         k0 = gain(np00, s);
         k1 = gain(np10, s);

         // correct
         y = meas - ang;
         angle_est = clamp32(ang + round_shift(k0 * y, 30));
         bias_est = clamp32(bias_est + round_shift(k1 * y, 30));
         cov[0] = clamp32(np00 - round_shift(k0 * np00, 30));
         cov[1] = clamp32(np01 - round_shift(k0 * np01, 30));
         cov[2] = clamp32(np10 - round_shift(k1 * np00, 30));
         cov[3] = clamp32(np11 - round_shift(k1 * np01, 30));

         e.filtered_angle = angle_est[31:0];
         e.estimated_bias = bias_est[31:0];
         estimate_q.push_back(e);
      endfunction

      function void check_result(agkf_rsp_type got);
         agkf_rsp_type e;
         if (estimate_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: angle %0d bias %0d",
                        got.filtered_angle, got.estimated_bias);
            return;
         end
         e = estimate_q.pop_front();
         if (got.filtered_angle !== e.filtered_angle) begin
            mismatches++;
            if (mismatches <= 10)
               $display("filtered_angle: expected %0d actual %0d",
                        e.filtered_angle, got.filtered_angle);
         end
         if (got.estimated_bias !== e.estimated_bias) begin
            mismatches++;
            if (mismatches <= 10)
               $display("estimated_bias: expected %0d actual %0d",
                        e.estimated_bias, got.estimated_bias);
         end
      endfunction

      function int pending();
         return estimate_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   agkf_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   agkf_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_NOISE_ANGLE;
   logic [31:0] csr_wdata = '0;

   kalman_scoreboard filter_sb = new();
   bit calm = 1'b0;
   int sent = 0;

   angle_gyro_kalman_filter_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check accepted words, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) filter_sb.check_result(rsp_data);
      rsp_ready <= calm || ($urandom_range(99) >= 17);
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      filter_sb.write_reg(idx, v);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold valid until accepted; valid stays high for a back-to-back word
   task automatic send_word(agkf_req_type w);
      if (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      filter_sb.note_input(w);
      sent++;
      calm = (sent >= 400 && sent < 700);
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (filter_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_fields(logic [31:0] m, logic [31:0] g, logic [15:0] dt);
      agkf_req_type w;
      w.measured_angle = m;
      w.gyro_rate = g;
      w.time_step = dt;
      send_word(w);
   endtask

   // mostly plausible motion, some raw noise and extreme steps
   task automatic send_random(ref longint true_angle);
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         true_angle += $signed($urandom_range(0, 4000)) - 2000;
         if (true_angle > 64'sd5898240 || true_angle < -64'sd5898240) true_angle = 0;
         send_fields(32'(true_angle + $signed($urandom_range(0, 8000)) - 4000),
                     32'($signed($urandom_range(0, 2000000)) - 1000000),
                     16'($urandom_range(0, 3000)));
      end else if (pick < 90) begin
         send_fields($urandom, $urandom, 16'($urandom));
      end else begin
         send_fields($urandom, $urandom, $urandom_range(1) ? 16'hffff : 16'h0000);
      end
   endtask

   initial begin
      longint true_angle;
      true_angle = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero noise: zero covariance and zero dt leave no innovation variance
      write_reg(CSR_NOISE_ANGLE, 32'd0);
      write_reg(CSR_NOISE_BIAS, 32'd0);
      write_reg(CSR_NOISE_MEAS, 32'd0);
      write_reg(CSR_SPARE, 32'hffffffff);
      send_fields(32'h7fffffff, 32'h7fffffff, 16'h0000);
      send_fields(32'h80000000, 32'h80000000, 16'h0000);
      send_fields(32'h00010000, 32'h00000000, 16'h0000);
      drain();

      // defaults, field extremes
      write_reg(CSR_NOISE_ANGLE, NOISE_ANGLE_RESET);
      write_reg(CSR_NOISE_BIAS, NOISE_BIAS_RESET);
      write_reg(CSR_NOISE_MEAS, NOISE_MEAS_RESET);
      send_fields(32'h00000000, 32'h00000000, 16'h0000);
      send_fields(32'h7fffffff, 32'h00000000, 16'hffff);
      send_fields(32'h80000000, 32'h00000000, 16'hffff);
      send_fields(32'h00000000, 32'h7fffffff, 16'hffff);
      send_fields(32'h00000000, 32'h80000000, 16'hffff);
      send_fields(32'h7fffffff, 32'h7fffffff, 16'hffff);
      send_fields(32'h80000000, 32'h80000000, 16'h0001);
      send_fields(32'hffffffff, 32'h00000001, 16'h0001);
      send_fields(32'h00050000, 32'h00020000, 16'h0290);
      send_fields(32'hfffb0000, 32'hfffe0000, 16'h0290);
      drain();

      // largest noise
      write_reg(CSR_NOISE_ANGLE, 32'hffffffff);
      write_reg(CSR_NOISE_BIAS, 32'hffffffff);
      write_reg(CSR_NOISE_MEAS, 32'hffffffff);
      repeat (RANDOM_WORDS / 5) send_random(true_angle);
      drain();

      // back to defaults for the longest random run
      write_reg(CSR_NOISE_ANGLE, NOISE_ANGLE_RESET);
      write_reg(CSR_NOISE_BIAS, NOISE_BIAS_RESET);
      write_reg(CSR_NOISE_MEAS, NOISE_MEAS_RESET);
      repeat (2 * RANDOM_WORDS / 5) send_random(true_angle);
      drain();

      // random settings
      repeat (2) begin
         write_reg(CSR_NOISE_ANGLE, $urandom);
         write_reg(CSR_NOISE_BIAS, $urandom >> $urandom_range(31));
         write_reg(CSR_NOISE_MEAS, $urandom >> $urandom_range(31));
         repeat (RANDOM_WORDS / 5) send_random(true_angle);
         drain();
      end

      if (filter_sb.mismatches == 0 && filter_sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
rtl/agkf_pkg.sv
rtl/angle_gyro_kalman_filter_core.sv
test/angle_gyro_kalman_filter_core_test.sv
